// File: design/weighted_linear_flux_fit_assert.svh
// Assertion macros for the flux fit block.
// IMP checks a same-cycle implication, NXT a next-cycle one.
// Both use the clk and rst of the module that expands them.
`ifndef WEIGHTED_LINEAR_FLUX_FIT_ASSERT_SVH
`define WEIGHTED_LINEAR_FLUX_FIT_ASSERT_SVH
`ifndef SYNTHESIS
`define WLFF_ASSERT_IMP(lbl, ante, cons) lbl: assert property (@(posedge clk) disable iff (rst) \
  (ante) |-> (cons)) else $error("flux fit: implication check failed");
`define WLFF_ASSERT_NXT(lbl, ante, cons) lbl: assert property (@(posedge clk) disable iff (rst) \
  (ante) |=> (cons)) else $error("flux fit: next-cycle check failed");
`else
`define WLFF_ASSERT_IMP(lbl, ante, cons)
`define WLFF_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// File: design/wlff_pkg.sv
package wlff_pkg;

  localparam int unsigned MAX_POINTS = 4096;
  localparam logic [62:0] CHI_MAX    = '1;

  // operand pair of the shared multiplier; also picks what is done with its product
  typedef enum logic [3:0] {
    MS_W_M,
    MS_WM_M,
    MS_WAA_W,
    MS_WA_WA,
    MS_WAF_W,
    MS_WA_WF,
    MS_WAA_WF,
    MS_WA_WAF,
    MS_FS_WAF,
    MS_FB_WF
  } mul_sel_t;

  typedef struct packed {
    logic     load_in;
    logic     mul_start;
    logic     mul_post;
    mul_sel_t mul_sel;
    logic     div_start;
    logic     div_post;
    logic     div_sel;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic mode;
    logic det_bad;
    logic mul_busy;
    logic div_busy;
    logic out_busy;
  } stat_t;

endpackage

// File: design/wlff_mul.sv
// 64x64 signed multiply, 8 bits of b per cycle, then a sign-fix step
module wlff_mul (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] a,
  input  logic signed [63:0] b,
  output logic               busy,
  output logic [127:0]       prod
);

  logic [63:0]  ua;
  logic [63:0]  l;
  logic [64:0]  h;
  logic         neg;
  logic [3:0]   cnt;
  logic [72:0]  s;
  logic [127:0] mag;
  logic [63:0]  a_abs;
  logic [63:0]  b_abs;

  always_comb begin
    s     = 73'(h) + 73'(ua * l[7:0]);
    mag   = {h[63:0], l};
    a_abs = a[63] ? 64'(-a) : 64'(a);
    b_abs = b[63] ? 64'(-b) : 64'(b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      if (cnt == 4'd8) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ua  <= a_abs;
      l   <= b_abs;
      h   <= '0;
      neg <= a[63] ^ b[63];
    end else if (busy) begin
      if (cnt == 4'd8) begin
        prod <= neg ? (128'd0 - mag) : mag;
      end else begin
        h <= s[72:8];
        l <= {s[7:0], l[63:8]};
      end
    end
  end

endmodule

// File: design/wlff_div.sv
// 128-bit unsigned restoring divide, one quotient bit per cycle
module wlff_div (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [127:0] n,
  input  logic [127:0] d,
  output logic         busy,
  output logic [127:0] q,
  output logic [127:0] r
);

  logic [6:0]   cnt;
  logic [127:0] rs;
  logic         ge;

  always_comb begin
    rs = {r[126:0], q[127]};
    ge = (rs >= d);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      if (cnt == 7'd127) begin
        busy <= 1'b0;
      end
      cnt <= cnt + 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q <= n;
      r <= '0;
    end else if (busy) begin
      r <= ge ? (rs - d) : rs;
      q <= {q[126:0], ge};
    end
  end

endmodule

// File: design/wlff_dp.sv
// Datapath: config, point products, sums, shared multiplier and divider, result register
module wlff_dp import wlff_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output stat_t              st,
  input  logic [11:0]        weight,
  input  logic [15:0]        magnification,
  input  logic signed [15:0] observed_flux,
  input  logic               last,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               out_stall,
  output logic               out_valid,
  output logic signed [31:0] source_flux,
  output logic signed [31:0] blend_flux,
  output logic [62:0]        chi_square,
  output logic               status,
  output logic [12:0]        points
);

  localparam logic [1:0]  REG_FLUX_MODE    = 2'd0;
  localparam logic [1:0]  REG_GIVEN_SOURCE = 2'd1;
  localparam logic [1:0]  REG_GIVEN_BLEND  = 2'd2;
  localparam logic [12:0] MAX_CNT          = 13'(MAX_POINTS);

  logic               mode;
  logic signed [31:0] gs;
  logic signed [31:0] gb;

  logic [11:0]        in_w;
  logic [15:0]        in_a;
  logic signed [15:0] in_f;
  logic               in_last;

  logic signed [28:0] s1_wf;
  logic [27:0]        s1_wa;
  logic signed [47:0] s1_gsa;
  logic signed [44:0] s2_wff;
  logic [43:0]        s2_waa;
  logic signed [44:0] s2_waf;
  logic [48:0]        s2_m;
  logic signed [48:0] resid;

  logic [24:0]        sum_w;
  logic signed [40:0] sum_wf;
  logic [55:0]        sum_wff;
  logic [40:0]        sum_wa;
  logic [55:0]        sum_waa;
  logic signed [56:0] sum_waf;
  logic [62:0]        residual;
  logic [12:0]        count;

  logic signed [63:0] ma;
  logic signed [63:0] mb;
  logic               mul_busy;
  logic [127:0]       mprod;
  mul_sel_t           cur_sel;

  logic [127:0] x_reg;
  logic [127:0] dreg;
  logic [127:0] nfs;
  logic [127:0] nfb;
  logic [127:0] treg;
  logic [127:0] diff;
  logic signed [31:0] fs;
  logic signed [31:0] fb;

  logic [127:0] pr;
  logic [63:0]  rsum;
  logic [62:0]  res_next;

  logic         div_busy;
  logic [127:0] dq;
  logic [127:0] dr;
  logic [127:0] dnum;
  logic [127:0] dmag;
  logic         pneg;
  logic         rnd;
  logic [127:0] qr;
  logic [127:0] limit;
  logic [31:0]  qval;

  logic         det_bad;
  logic [127:0] tu;
  logic [62:0]  chi_fit;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b0;
      gs   <= '0;
      gb   <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FLUX_MODE:    mode <= cfg_data[0];
        REG_GIVEN_SOURCE: gs   <= cfg_data;
        REG_GIVEN_BLEND:  gb   <= cfg_data;
        default: ;
      endcase
    end
  end

  // point capture and the two product stages
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_w    <= weight;
      in_a    <= magnification;
      in_f    <= observed_flux;
      in_last <= last;
    end
    s1_wf  <= $signed({1'b0, in_w}) * in_f;
    s1_wa  <= in_w * in_a;
    s1_gsa <= gs * $signed({1'b0, in_a});
    s2_wff <= s1_wf * in_f;
    s2_waa <= s1_wa * in_a;
    s2_waf <= $signed({1'b0, s1_wa}) * in_f;
    s2_m   <= resid[48] ? 49'(-resid) : 49'(resid);
  end

  always_comb begin
    resid = (49'(in_f) <<< 24) - 49'(s1_gsa) - (49'(gb) <<< 8);
  end

  // multiplier operands
  always_comb begin
    case (cmd.mul_sel)
      MS_W_M:    begin ma = 64'(in_w);       mb = 64'(s2_m);    end
      MS_WM_M:   begin ma = mprod[63:0];     mb = 64'(s2_m);    end
      MS_WAA_W:  begin ma = 64'(sum_waa);    mb = 64'(sum_w);   end
      MS_WA_WA:  begin ma = 64'(sum_wa);     mb = 64'(sum_wa);  end
      MS_WAF_W:  begin ma = 64'(sum_waf);    mb = 64'(sum_w);   end
      MS_WA_WF:  begin ma = 64'(sum_wa);     mb = 64'(sum_wf);  end
      MS_WAA_WF: begin ma = 64'(sum_waa);    mb = 64'(sum_wf);  end
      MS_WA_WAF: begin ma = 64'(sum_wa);     mb = 64'(sum_waf); end
      MS_FS_WAF: begin ma = 64'(fs);         mb = 64'(sum_waf); end
      MS_FB_WF:  begin ma = 64'(fb);         mb = 64'(sum_wf);  end
      default:   begin ma = '0;              mb = '0;           end
    endcase
  end

  wlff_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mul_start),
    .a     (ma),
    .b     (mb),
    .busy  (mul_busy),
    .prod  (mprod)
  );

  always_comb begin
    diff     = x_reg - mprod;
    pr       = mprod + (128'd1 << 47);
    rsum     = 64'(residual) + pr[111:48];
    res_next = rsum[63] ? CHI_MAX : rsum[62:0];
  end

  // running sums, cleared once a result is taken into the output register
  always_ff @(posedge clk) begin
    if (rst || cmd.out_load) begin
      sum_w    <= '0;
      sum_wf   <= '0;
      sum_wff  <= '0;
      sum_wa   <= '0;
      sum_waa  <= '0;
      sum_waf  <= '0;
      residual <= '0;
      count    <= '0;
    end else if (cmd.mul_post && cur_sel == MS_WM_M && count < MAX_CNT) begin
      sum_w    <= sum_w + 25'(in_w);
      sum_wf   <= sum_wf + 41'(s1_wf);
      sum_wff  <= sum_wff + 56'(s2_wff);
      sum_wa   <= sum_wa + 41'(s1_wa);
      sum_waa  <= sum_waa + 56'(s2_waa);
      sum_waf  <= sum_waf + 57'(s2_waf);
      residual <= res_next;
      count    <= count + 13'd1;
    end
  end

  // solve intermediates
  always_ff @(posedge clk) begin
    if (cmd.mul_start) begin
      cur_sel <= cmd.mul_sel;
    end
    if (cmd.mul_post) begin
      case (cur_sel)
        MS_WAA_W, MS_WAF_W, MS_WAA_WF: x_reg <= mprod;
        MS_WA_WA:  dreg <= diff;
        MS_WA_WF:  nfs  <= diff << 24;
        MS_WA_WAF: nfb  <= diff << 16;
        MS_FS_WAF: treg <= (128'(sum_wff) << 12) - mprod;
        MS_FB_WF:  treg <= treg - (mprod << 8);
        default: ;
      endcase
    end
    if (cmd.div_post) begin
      if (cmd.div_sel) begin
        fb <= qval;
      end else begin
        fs <= qval;
      end
    end
  end

  always_comb begin
    dnum  = cmd.div_sel ? nfb : nfs;
    pneg  = dnum[127];
    dmag  = pneg ? (128'd0 - dnum) : dnum;
    rnd   = ({dr[126:0], 1'b0} >= dreg);
    qr    = dq + 128'(rnd);
    limit = pneg ? 128'h8000_0000 : 128'h7FFF_FFFF;
    if (qr > limit) begin
      qval = pneg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      qval = pneg ? (32'd0 - qr[31:0]) : qr[31:0];
    end
  end

  wlff_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .n     (dmag),
    .d     (dreg),
    .busy  (div_busy),
    .q     (dq),
    .r     (dr)
  );

  always_comb begin
    det_bad = dreg[127] || (dreg == '0);
    tu      = treg + (128'd1 << 11);
    if (treg[127]) begin
      chi_fit = '0;
    end else if (|tu[127:75]) begin
      chi_fit = CHI_MAX;
    end else begin
      chi_fit = tu[74:12];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      points <= count;
      if (mode) begin
        source_flux <= gs;
        blend_flux  <= gb;
        chi_square  <= residual;
        status      <= 1'b0;
      end else if (det_bad) begin
        source_flux <= '0;
        blend_flux  <= '0;
        chi_square  <= CHI_MAX;
        status      <= 1'b1;
      end else begin
        source_flux <= fs;
        blend_flux  <= fb;
        chi_square  <= chi_fit;
        status      <= 1'b0;
      end
    end
  end

  always_comb begin
    st.last     = in_last;
    st.mode     = mode;
    st.det_bad  = det_bad;
    st.mul_busy = mul_busy;
    st.div_busy = div_busy;
    st.out_busy = out_valid && out_stall;
  end

endmodule

// File: design/wlff_ctrl.sv
// Sequencer: point products, residual multiplies, then the closed-form solve
module wlff_ctrl import wlff_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  stat_t st,
  output cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_P1,
    S_P2,
    S_MGO,
    S_MWAIT,
    S_DGO,
    S_DWAIT,
    S_OUT
  } state_t;

  state_t   state;
  mul_sel_t step;
  logic     dsel;
  logic     skip_fit;

  assign skip_fit = (step == MS_WAF_W) && st.det_bad;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= MS_W_M;
      dsel  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_P1;
            step  <= MS_W_M;
          end
        end
        S_P1: state <= S_P2;
        S_P2: state <= S_MGO;
        S_MGO: begin
          state <= skip_fit ? S_OUT : S_MWAIT;
        end
        S_MWAIT: begin
          if (!st.mul_busy) begin
            case (step)
              MS_W_M: begin
                step  <= MS_WM_M;
                state <= S_MGO;
              end
              MS_WM_M: begin
                if (!st.last) begin
                  state <= S_IDLE;
                end else if (st.mode) begin
                  state <= S_OUT;
                end else begin
                  step  <= MS_WAA_W;
                  state <= S_MGO;
                end
              end
              MS_WAA_W:  begin step <= MS_WA_WA;  state <= S_MGO; end
              MS_WA_WA:  begin step <= MS_WAF_W;  state <= S_MGO; end
              MS_WAF_W:  begin step <= MS_WA_WF;  state <= S_MGO; end
              MS_WA_WF:  begin step <= MS_WAA_WF; state <= S_MGO; end
              MS_WAA_WF: begin step <= MS_WA_WAF; state <= S_MGO; end
              MS_WA_WAF: begin dsel <= 1'b0;      state <= S_DGO; end
              MS_FS_WAF: begin step <= MS_FB_WF;  state <= S_MGO; end
              MS_FB_WF:  state <= S_OUT;
              default:   state <= S_IDLE;
            endcase
          end
        end
        S_DGO: state <= S_DWAIT;
        S_DWAIT: begin
          if (!st.div_busy) begin
            if (!dsel) begin
              dsel  <= 1'b1;
              state <= S_DGO;
            end else begin
              step  <= MS_FS_WAF;
              state <= S_MGO;
            end
          end
        end
        S_OUT: begin
          if (!st.out_busy) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    in_stall      = (state != S_IDLE);
    cmd.load_in   = (state == S_IDLE) && in_valid;
    cmd.mul_start = (state == S_MGO) && !skip_fit;
    cmd.mul_post  = (state == S_MWAIT) && !st.mul_busy;
    cmd.mul_sel   = step;
    cmd.div_start = (state == S_DGO);
    cmd.div_post  = (state == S_DWAIT) && !st.div_busy;
    cmd.div_sel   = dsel;
    cmd.out_load  = (state == S_OUT) && !st.out_busy;
  end

endmodule

// File: design/weighted_linear_flux_fit.sv
// Each point beat is worked on before the next is taken; the channel stalls while the
// two passes of the shared 64x64 multiplier (8 bits a cycle) run for that point.
// A last point in fit mode adds eight multiplies and two divides on the 128-bit
// restoring divider. In given-flux mode it goes straight to loading the result register.
// Reset (rst, synchronous, active high) clears config, sums, count and control;
// no clearing pass is needed.
module weighted_linear_flux_fit import wlff_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  // point channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [11:0]        weight,
  input  logic [15:0]        magnification,
  input  logic signed [15:0] observed_flux,
  input  logic               last,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] source_flux,
  output logic signed [31:0] blend_flux,
  output logic [62:0]        chi_square,
  output logic               status,
  output logic [12:0]        points,
  // config write port
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

`include "weighted_linear_flux_fit_assert.svh"

  // command and status between sequencer and datapath
  cmd_t  cmd;
  stat_t st;

  // Sequencer: takes one point beat at a time, runs the residual multiplies,
  // and on the last beat in fit mode walks the solve (determinant, numerators, divides,
  // chi-square) before loading the result register.
  wlff_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // Datapath: two product stages per point, six weighted sums plus the
  // given-flux residual sum, the shared multiplier and divider, and a result
  // register that lets the next data set start while a result waits.
  wlff_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .st            (st),
    .weight        (weight),
    .magnification (magnification),
    .observed_flux (observed_flux),
    .last          (last),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .source_flux   (source_flux),
    .blend_flux    (blend_flux),
    .chi_square    (chi_square),
    .status        (status),
    .points        (points)
  );

  // multiplier and divider are never run together
  `WLFF_ASSERT_IMP(a_units_excl, st.mul_busy, !st.div_busy)
  // a taken point beat blocks the channel while it is worked on
  `WLFF_ASSERT_NXT(a_point_blocks, in_valid && !in_stall, in_stall)
  // count never passes the data set limit
  `WLFF_ASSERT_IMP(a_points_cap, out_valid, points <= 13'(MAX_POINTS))
  // a singular result carries zero fluxes and saturated chi-square
  `WLFF_ASSERT_IMP(a_singular, out_valid && status,
                   source_flux == 32'sd0 && blend_flux == 32'sd0 && chi_square == CHI_MAX)

endmodule

// File: tb/weighted_linear_flux_fit_tb.sv
module weighted_linear_flux_fit_tb;
  import wlff_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // config register indexes; index 3 decodes to nothing
  localparam logic [1:0] REG_FLUX_MODE = 2'd0;
  localparam logic [1:0] REG_SOURCE    = 2'd1;
  localparam logic [1:0] REG_BLEND     = 2'd2;
  localparam logic [1:0] REG_UNUSED    = 2'd3;

  localparam int SETTLE_CYCLES = 420;  // worst case fit solve, plus margin

  typedef struct packed {
    logic signed [31:0] source_flux;
    logic signed [31:0] blend_flux;
    logic [62:0]        chi_square;
    logic               status;
    logic [12:0]        points;
  } fit_result_t;

  // Fit predictor and result store.
  class flux_fit_board;
    longint      s_w, s_wf, s_wff, s_wa, s_waa, s_waf;
    logic [63:0] resid = '0;
    int          held;
    fit_result_t pending[$];
    int          n_bad;

    function void clear_sums();
      s_w = 0; s_wf = 0; s_wff = 0; s_wa = 0; s_waa = 0; s_waf = 0;
      resid = 0; held = 0;
    endfunction

    function logic signed [127:0] wide(longint x);
      logic signed [127:0] v;
      v = x;
      return v;
    endfunction

    // rounded divide, ties away from zero, saturated to 32 bits
    function logic signed [31:0] round_div(logic signed [127:0] num,
                                           logic signed [127:0] den);
      logic [127:0] m, q, rm, d;
      logic         neg;
      neg = num[127];
      d   = den;
      m   = neg ? -num : num;
      q   = m / d;
      rm  = m % d;
      if ((rm << 1) >= d) q = q + 1;
      if (neg) return (q > 128'h8000_0000) ? 32'sh8000_0000 : -q[31:0];
      return (q > 128'h7FFF_FFFF) ? 32'sh7FFF_FFFF : q[31:0];
    endfunction

    function void note_point(logic [11:0] w, logic [15:0] a, logic signed [15:0] f,
                             logic l, logic mode, logic signed [31:0] gs,
                             logic signed [31:0] gb);
      longint              wl, al, fl, r, mag;
      logic [127:0]        p;
      logic [64:0]         acc;
      logic signed [127:0] d, nfs, nfb, t;
      fit_result_t         e;
      wl = w; al = a; fl = f;
      if (held < MAX_POINTS) begin
        r   = fl * 64'sd16777216 - longint'(gs) * al - longint'(gb) * 256;
        mag = (r < 0) ? -r : r;
        p   = 128'(wl) * 128'(mag) * 128'(mag) + (128'd1 << 47);
        acc = 65'(resid) + 65'(p[111:48]);
        resid = (acc > 65'(CHI_MAX)) ? 64'(CHI_MAX) : acc[63:0];
        s_w += wl; s_wf += wl * fl; s_wff += wl * fl * fl;
        s_wa += wl * al; s_waa += wl * al * al; s_waf += wl * al * fl;
        held++;
      end
      if (!l) return;
      e.status = 1'b0;
      if (mode) begin
        e.source_flux = gs;
        e.blend_flux  = gb;
        e.chi_square  = resid[62:0];
      end else begin
        d = wide(s_waa) * wide(s_w) - wide(s_wa) * wide(s_wa);
        if (d <= 0) begin
          e.source_flux = '0; e.blend_flux = '0; e.chi_square = CHI_MAX; e.status = 1'b1;
        end else begin
          nfs = (wide(s_waf) * wide(s_w) - wide(s_wa) * wide(s_wf)) <<< 24;
          nfb = (wide(s_waa) * wide(s_wf) - wide(s_wa) * wide(s_waf)) <<< 16;
          e.source_flux = round_div(nfs, d);
          e.blend_flux  = round_div(nfb, d);
          t = (wide(s_wff) <<< 12) - wide(longint'(e.source_flux)) * wide(s_waf)
              - ((wide(longint'(e.blend_flux)) * wide(s_wf)) <<< 8);
          if (t < 0) e.chi_square = '0;
          else begin
            t = (t + 2048) >>> 12;
            e.chi_square = (t > 128'(CHI_MAX)) ? CHI_MAX : t[62:0];
          end
        end
      end
      e.points = held[12:0];
      pending = {pending, e};
      clear_sums();
    endfunction

    function void check_result(fit_result_t got);
      fit_result_t e;
      if (pending.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected result beat: %p", got);
        return;
      end
      e = pending.pop_front();
      if (got !== e) begin
        n_bad++;
        // each pair is expected then actual
        if (n_bad <= 10)
          $display("mismatch fs %0d/%0d fb %0d/%0d chi %0d/%0d st %0b/%0b pts %0d/%0d",
                   e.source_flux, got.source_flux, e.blend_flux, got.blend_flux,
                   e.chi_square, got.chi_square, e.status, got.status,
                   e.points, got.points);
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [11:0]        weight = '0;
  logic [15:0]        magnification = '0;
  logic signed [15:0] observed_flux = '0;
  logic               last = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] source_flux;
  logic signed [31:0] blend_flux;
  logic [62:0]        chi_square;
  logic               status;
  logic [12:0]        points;
  logic               cfg_write = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;

  weighted_linear_flux_fit u_dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  flux_fit_board board = new();

  // local copy of the registers, as the block holds them
  logic               mode_q = 1'b0;
  logic signed [31:0] src_q = '0;
  logic signed [31:0] blend_q = '0;

  int tx_idle = 0;       // percent of cycles the sender sits out
  int rx_idle = 0;       // percent of cycles the receiver stalls
  int rx_hold = 0;       // long receiver hold-off, counted down below

  // receiver: stall pattern plus result check at the edge
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      board.check_result({source_flux, blend_flux, chi_square, status, points});
    if (rx_hold > 0) begin
      rx_hold   <= rx_hold - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle);
    end
  end

  // one point beat; held steady until taken, valid left for the next caller
  task automatic send_point(logic [11:0] w, logic [15:0] a, logic signed [15:0] f,
                            logic l);
    while ($urandom_range(99) < tx_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    weight        <= w;
    magnification <= a;
    observed_flux <= f;
    last          <= l;
    do @(posedge clk); while (in_stall);
    board.note_point(w, a, f, l, mode_q, src_q, blend_q);
  endtask

  // wait for every result, then let a solve in flight finish
  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_FLUX_MODE: mode_q  = val[0];
      REG_SOURCE:    src_q   = val;
      REG_BLEND:     blend_q = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_regs(logic m, logic [31:0] s, logic [31:0] b);
    drain();
    write_reg(REG_FLUX_MODE, {31'd0, m});
    write_reg(REG_SOURCE, s);
    write_reg(REG_BLEND, b);
  endtask

  // one data set: mostly points near a line, sometimes raw noise
  task automatic send_set(int len);
    int     fs_int, fb_int, ff;
    logic   noisy;
    logic [15:0] a;
    fs_int = $urandom_range(40) - 20;
    fb_int = $urandom_range(2000) - 1000;
    noisy  = ($urandom_range(99) < 25);
    for (int i = 0; i < len; i++) begin
      a = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(2560, 128));
      ff = noisy ? int'($urandom_range(65535)) - 32768
                 : fs_int * int'(a) / 256 + fb_int + int'($urandom_range(20)) - 10;
      if (ff > 32767) ff = 32767;
      if (ff < -32768) ff = -32768;
      send_point(12'($urandom), a, 16'(ff), i == len - 1);
    end
  endtask

  task automatic random_sets(int n_items);
    int sent, len;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
      send_set(len);
      sent += len;
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: lone extreme point is singular
    send_point(12'hFFF, 16'hFFFF, -16'sd32768, 1'b1);
    // zero weights, singular too
    send_point(12'd0, 16'd256, 16'sd5, 1'b0);
    send_point(12'd0, 16'd512, 16'sd9, 1'b1);
    // same magnification everywhere leaves the system singular
    send_point(12'd100, 16'd300, 16'sd1, 1'b0);
    send_point(12'd200, 16'd300, 16'sd2, 1'b1);
    // clean three-point fit at field extremes
    send_point(12'hFFF, 16'd0, 16'sd32767, 1'b0);
    send_point(12'hFFF, 16'hFFFF, -16'sd32768, 1'b0);
    send_point(12'd1, 16'h8000, 16'sd0, 1'b1);
    // exact line gives chi near zero
    send_point(12'd2048, 16'd256, 16'sd30, 1'b0);
    send_point(12'd2048, 16'd512, 16'sd50, 1'b0);
    send_point(12'd2048, 16'd768, 16'sd70, 1'b1);

    // given-flux mode at the register extremes, chi saturating
    set_regs(1'b1, 32'h8000_0000, 32'h7FFF_FFFF);
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    send_point(12'hFFF, 16'hFFFF, -16'sd32768, 1'b0);
    send_point(12'hFFF, 16'hFFFF, 16'sd32767, 1'b1);
    set_regs(1'b1, 32'h0001_0000, 32'hFFFF_0000);
    send_point(12'd4000, 16'd256, 16'sd0, 1'b1);

    // register change in the middle of a set
    send_point(12'd1000, 16'd700, 16'sd12, 1'b0);
    set_regs(1'b1, 32'h0003_0000, 32'h0000_8000);
    send_point(12'd1500, 16'd900, -16'sd7, 1'b0);
    set_regs(1'b0, 32'h0003_0000, 32'h0000_8000);
    send_point(12'd900, 16'd100, 16'sd3, 1'b1);

    // full data set: points past the limit are dropped
    for (int i = 0; i < MAX_POINTS + 4; i++)
      send_point(12'($urandom), 16'($urandom), 16'($urandom), i == MAX_POINTS + 3);

    // random phases with differing idling and settings
    tx_idle = 28; rx_idle = 75;
    random_sets(330);
    set_regs(1'b1, 32'($urandom_range(8_000_000)) - 32'd4_000_000, 32'($urandom));
    tx_idle = 75; rx_idle = 28;
    random_sets(330);
    set_regs(1'b0, 32'h0, 32'h0);
    tx_idle = 0; rx_idle = 0;
    // long receiver hold-off while points keep coming
    rx_hold = 3000;
    random_sets(100);
    drain();
    set_regs(1'b1, 32'($urandom), 32'($urandom));
    random_sets(120);
    set_regs(1'b0, 32'h0, 32'h0);
    random_sets(120);

    drain();
    if (board.n_bad == 0 && board.pending.size() == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #60ms;
    $display("Verification failed");
    $finish;
  end

endmodule
